// ===== design/msf_pkg.sv =====
// Shared types and codes for the mission supervisor.
// Mode, event and reason codes plus the decode result struct.
// No dependencies.
package msf_pkg;

  // Mission modes
  localparam logic [3:0] MODE_IDLE       = 4'd0;
  localparam logic [3:0] MODE_READY      = 4'd1;
  localparam logic [3:0] MODE_RUNNING    = 4'd2;
  localparam logic [3:0] MODE_PAUSING    = 4'd3;
  localparam logic [3:0] MODE_PAUSED     = 4'd4;
  localparam logic [3:0] MODE_RECOVERING = 4'd5;
  localparam logic [3:0] MODE_RETURNING  = 4'd6;
  localparam logic [3:0] MODE_COMPLETED  = 4'd7;
  localparam logic [3:0] MODE_FAILED     = 4'd8;

  // Event codes
  localparam logic [3:0] EV_CONFIGURED = 4'd0;
  localparam logic [3:0] EV_START      = 4'd1;
  localparam logic [3:0] EV_PAUSE      = 4'd2;
  localparam logic [3:0] EV_TAKEOVER   = 4'd3;
  localparam logic [3:0] EV_LINK       = 4'd4;
  localparam logic [3:0] EV_SAFETY     = 4'd5;
  localparam logic [3:0] EV_AUTHORITY  = 4'd6;
  localparam logic [3:0] EV_STOP       = 4'd7;
  localparam logic [3:0] EV_FATAL      = 4'd8;
  localparam logic [3:0] EV_QUIESCED   = 4'd9;
  localparam logic [3:0] EV_RESUME     = 4'd10;
  localparam logic [3:0] EV_RECOVERY   = 4'd11;
  localparam logic [3:0] EV_INSPECTION = 4'd12;
  localparam logic [3:0] EV_RETURN     = 4'd13;
  localparam logic [3:0] EV_RESET      = 4'd14;

  // Reason codes
  localparam logic [4:0] RSN_CONFIGURED        = 5'd0;
  localparam logic [4:0] RSN_ALREADY_STOPPED   = 5'd1;
  localparam logic [4:0] RSN_INVALID_IDLE      = 5'd2;
  localparam logic [4:0] RSN_STARTED           = 5'd3;
  localparam logic [4:0] RSN_READY_CLEARED     = 5'd4;
  localparam logic [4:0] RSN_INVALID_READY     = 5'd5;
  localparam logic [4:0] RSN_HALT_PAUSE        = 5'd6;
  localparam logic [4:0] RSN_HALT_CLEAR        = 5'd7;
  localparam logic [4:0] RSN_HALT_FAIL         = 5'd8;
  localparam logic [4:0] RSN_DOCK_STARTED      = 5'd9;
  localparam logic [4:0] RSN_INSPECTION_DONE   = 5'd10;
  localparam logic [4:0] RSN_DOCK_DONE         = 5'd11;
  localparam logic [4:0] RSN_INVALID_ACTIVE    = 5'd12;
  localparam logic [4:0] RSN_QUIESCENT         = 5'd13;
  localparam logic [4:0] RSN_STOP_RECORDED     = 5'd14;
  localparam logic [4:0] RSN_FAIL_RECORDED     = 5'd15;
  localparam logic [4:0] RSN_PAUSE_IN_PROGRESS = 5'd16;
  localparam logic [4:0] RSN_INVALID_PAUSING   = 5'd17;
  localparam logic [4:0] RSN_RECOVERY_STARTED  = 5'd18;
  localparam logic [4:0] RSN_PAUSED_CLEARED    = 5'd19;
  localparam logic [4:0] RSN_ALREADY_PAUSED    = 5'd20;
  localparam logic [4:0] RSN_INVALID_PAUSED    = 5'd21;
  localparam logic [4:0] RSN_PHASE_RESTARTED   = 5'd22;
  localparam logic [4:0] RSN_RECOVERY_CANCEL   = 5'd23;
  localparam logic [4:0] RSN_RECOVER_CLEARED   = 5'd24;
  localparam logic [4:0] RSN_INVALID_RECOVER   = 5'd25;
  localparam logic [4:0] RSN_TERMINAL_CLEARED  = 5'd26;
  localparam logic [4:0] RSN_TERMINAL_RESET    = 5'd27;
  localparam logic [4:0] RSN_UNKNOWN_MODE      = 5'd28;

  // Output payload width, padded to whole bytes
  localparam int OUT_BITS = 24;

  // Supervisor state seen by the decoder
  typedef struct packed {
    logic [3:0] mode;
    logic [3:0] halt_mode;
    logic [3:0] resume_mode;
  } sup_state_t;

  // Outcome of one event
  typedef struct packed {
    logic [3:0] to_mode;
    logic       accepted;
    logic [4:0] reason_code;
    logic [3:0] halt_mode;
    logic [3:0] resume_mode;
  } step_result_t;

endpackage

// ===== design/msf_decode.sv =====
// Next-state decode of the mission supervisor for one event.
// Purely combinational; depends on msf_pkg.
module msf_decode (
  input  msf_pkg::sup_state_t   cur,
  input  logic [3:0]            event_code,
  input  logic                  dock_after_inspect,
  output msf_pkg::step_result_t res
);

  logic pause_like;

  assign pause_like = event_code inside {msf_pkg::EV_PAUSE, msf_pkg::EV_TAKEOVER,
                                         msf_pkg::EV_LINK, msf_pkg::EV_SAFETY,
                                         msf_pkg::EV_AUTHORITY};

  // Decode the transition from mode and event
  always_comb begin
    res.to_mode     = cur.mode;
    res.accepted    = 1'b1;
    res.reason_code = msf_pkg::RSN_UNKNOWN_MODE;
    res.halt_mode   = cur.halt_mode;
    res.resume_mode = cur.resume_mode;
    case (cur.mode)
      msf_pkg::MODE_IDLE: begin
        if (event_code == msf_pkg::EV_CONFIGURED) begin
          res.to_mode     = msf_pkg::MODE_READY;
          res.reason_code = msf_pkg::RSN_CONFIGURED;
        end else if (event_code == msf_pkg::EV_STOP) begin
          res.to_mode     = msf_pkg::MODE_IDLE;
          res.reason_code = msf_pkg::RSN_ALREADY_STOPPED;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_INVALID_IDLE;
        end
      end
      msf_pkg::MODE_READY: begin
        if (event_code == msf_pkg::EV_START) begin
          res.to_mode     = msf_pkg::MODE_RUNNING;
          res.reason_code = msf_pkg::RSN_STARTED;
        end else if (event_code == msf_pkg::EV_STOP) begin
          res.to_mode     = msf_pkg::MODE_IDLE;
          res.reason_code = msf_pkg::RSN_READY_CLEARED;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_INVALID_READY;
        end
      end
      msf_pkg::MODE_RUNNING, msf_pkg::MODE_RETURNING: begin
        // Halting events go through pausing and remember the active mode
        if (pause_like || event_code == msf_pkg::EV_STOP ||
            event_code == msf_pkg::EV_FATAL) begin
          res.to_mode     = msf_pkg::MODE_PAUSING;
          res.resume_mode = cur.mode;
          if (pause_like) begin
            res.halt_mode   = msf_pkg::MODE_PAUSED;
            res.reason_code = msf_pkg::RSN_HALT_PAUSE;
          end else if (event_code == msf_pkg::EV_STOP) begin
            res.halt_mode   = msf_pkg::MODE_IDLE;
            res.reason_code = msf_pkg::RSN_HALT_CLEAR;
          end else begin
            res.halt_mode   = msf_pkg::MODE_FAILED;
            res.reason_code = msf_pkg::RSN_HALT_FAIL;
          end
        end else if (cur.mode == msf_pkg::MODE_RUNNING &&
                     event_code == msf_pkg::EV_INSPECTION) begin
          if (dock_after_inspect) begin
            res.to_mode     = msf_pkg::MODE_RETURNING;
            res.reason_code = msf_pkg::RSN_DOCK_STARTED;
          end else begin
            res.to_mode     = msf_pkg::MODE_COMPLETED;
            res.reason_code = msf_pkg::RSN_INSPECTION_DONE;
          end
        end else if (cur.mode == msf_pkg::MODE_RETURNING &&
                     event_code == msf_pkg::EV_RETURN) begin
          res.to_mode     = msf_pkg::MODE_COMPLETED;
          res.reason_code = msf_pkg::RSN_DOCK_DONE;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_INVALID_ACTIVE;
        end
      end
      msf_pkg::MODE_PAUSING: begin
        if (event_code == msf_pkg::EV_QUIESCED) begin
          res.to_mode     = cur.halt_mode;
          res.reason_code = msf_pkg::RSN_QUIESCENT;
        end else if (event_code == msf_pkg::EV_STOP) begin
          res.halt_mode   = msf_pkg::MODE_IDLE;
          res.reason_code = msf_pkg::RSN_STOP_RECORDED;
        end else if (event_code == msf_pkg::EV_FATAL) begin
          // A recorded stop outranks a later failure
          if (cur.halt_mode != msf_pkg::MODE_IDLE) begin
            res.halt_mode = msf_pkg::MODE_FAILED;
          end
          res.reason_code = msf_pkg::RSN_FAIL_RECORDED;
        end else if (pause_like) begin
          res.reason_code = msf_pkg::RSN_PAUSE_IN_PROGRESS;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_INVALID_PAUSING;
        end
      end
      msf_pkg::MODE_PAUSED: begin
        if (event_code == msf_pkg::EV_RESUME) begin
          res.to_mode     = msf_pkg::MODE_RECOVERING;
          res.reason_code = msf_pkg::RSN_RECOVERY_STARTED;
        end else if (event_code == msf_pkg::EV_STOP) begin
          res.to_mode     = msf_pkg::MODE_IDLE;
          res.reason_code = msf_pkg::RSN_PAUSED_CLEARED;
        end else if (pause_like) begin
          res.reason_code = msf_pkg::RSN_ALREADY_PAUSED;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_INVALID_PAUSED;
        end
      end
      msf_pkg::MODE_RECOVERING: begin
        if (event_code == msf_pkg::EV_RECOVERY) begin
          res.to_mode     = cur.resume_mode;
          res.reason_code = msf_pkg::RSN_PHASE_RESTARTED;
        end else if (event_code == msf_pkg::EV_SAFETY ||
                     event_code == msf_pkg::EV_LINK) begin
          res.to_mode     = msf_pkg::MODE_PAUSED;
          res.reason_code = msf_pkg::RSN_RECOVERY_CANCEL;
        end else if (event_code == msf_pkg::EV_STOP) begin
          res.to_mode     = msf_pkg::MODE_IDLE;
          res.reason_code = msf_pkg::RSN_RECOVER_CLEARED;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_INVALID_RECOVER;
        end
      end
      msf_pkg::MODE_COMPLETED, msf_pkg::MODE_FAILED: begin
        if (event_code == msf_pkg::EV_RESET || event_code == msf_pkg::EV_STOP) begin
          res.to_mode     = msf_pkg::MODE_IDLE;
          res.reason_code = msf_pkg::RSN_TERMINAL_CLEARED;
        end else begin
          res.accepted    = 1'b0;
          res.reason_code = msf_pkg::RSN_TERMINAL_RESET;
        end
      end
      default: begin
        res.accepted    = 1'b0;
        res.reason_code = msf_pkg::RSN_UNKNOWN_MODE;
      end
    endcase
  end

endmodule

// ===== design/mission_supervisor_fsm.sv =====
// Mission supervisor top level: an accepted event goes through the input
// register, then the result register, to its result on the master side.
// Throughput is one event per cycle while m_tready is high; the result
// register holds under backpressure; the input register can take one more.
// Synchronous active-high reset returns the mode and both targets to idle,
// clears the dock option and empties both registers.
module mission_supervisor_fsm (
  input  logic       clk,
  input  logic       rst,
  // Configuration: dock after inspection
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // Event input; s_tdata: [3:0] event_code, [7:4] zero
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  // Result; m_tdata: [3:0] from_mode, [7:4] to_mode, [8] accepted,
  // [13:9] reason_code, [14] motion_allowed, [18:15] halt_goal,
  // [22:19] resume_goal, [23] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [msf_pkg::OUT_BITS-1:0] m_tdata
);

  msf_pkg::sup_state_t   state;
  msf_pkg::step_result_t res;
  logic                  dock_after_inspect;
  logic                  in_valid;
  logic [3:0]            in_event;
  logic                  out_valid;
  logic [msf_pkg::OUT_BITS-1:0] out_data;
  logic                  advance;
  logic                  motion;

  // Move the input register forward when the result register is free
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  msf_decode u_decode (
    .cur                (state),
    .event_code         (in_event),
    .dock_after_inspect (dock_after_inspect),
    .res                (res)
  );

  assign motion = (res.to_mode == msf_pkg::MODE_RUNNING) ||
                  (res.to_mode == msf_pkg::MODE_RETURNING);

  // Control state, supervisor state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid           <= 1'b0;
      out_valid          <= 1'b0;
      state.mode         <= msf_pkg::MODE_IDLE;
      state.halt_mode    <= msf_pkg::MODE_IDLE;
      state.resume_mode  <= msf_pkg::MODE_IDLE;
      dock_after_inspect <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (advance && in_valid) begin
        state.mode        <= res.to_mode;
        state.halt_mode   <= res.halt_mode;
        state.resume_mode <= res.resume_mode;
      end
      if (cfg_wr_en && state.mode == msf_pkg::MODE_IDLE) begin
        dock_after_inspect <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_event <= s_tdata[3:0];
    end
    if (advance && in_valid) begin
      out_data <= {1'b0, res.resume_mode, res.halt_mode, motion,
                   res.reason_code, res.accepted, res.to_mode, state.mode};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== design/msf_checker.sv =====
// Port-level checks for the mission supervisor, bound to the top level.
// Depends on msf_pkg and mission_supervisor_fsm.
module msf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [msf_pkg::OUT_BITS-1:0] m_tdata
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A rejected event leaves the mode unchanged
  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] || m_tdata[3:0] == m_tdata[7:4]))
    else $error("rejected event changed mode");

  // Motion flag follows the new mode
  a_motion: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[14] == ((m_tdata[7:4] == msf_pkg::MODE_RUNNING) ||
                                 (m_tdata[7:4] == msf_pkg::MODE_RETURNING)))
    else $error("motion flag mismatch");

  // An empty pipeline leaves room for a new transaction
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    $past(!s_tvalid) && !m_tvalid |-> s_tready)
    else $error("input stalled with empty pipeline");

endmodule

bind mission_supervisor_fsm msf_checker u_msf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/msf_transition_checker.sv =====
// Transition checker for mission_supervisor_fsm: watches the event, result and config ports.
// It predicts each transition record and compares it field by field with the block's output.
// Depends on msf_pkg for mode, event and reason codes.
`timescale 1ns / 1ps

module msf_transition_checker
  import msf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OUT_BITS-1:0] m_tdata,
  output int                  errors,
  output int                  pending
);

  // One transition record as it leaves the block
  typedef struct packed {
    logic [3:0] from_mode;
    logic [3:0] to_mode;
    logic       accepted;
    logic [4:0] reason_code;
    logic       motion_allowed;
    logic [3:0] halt_goal;
    logic [3:0] resume_goal;
  } transition_t;

  // Mirror of the supervisor state
  logic [3:0]  sup_mode    = MODE_IDLE;
  logic [3:0]  halt_goal   = MODE_IDLE;
  logic [3:0]  resume_goal = MODE_IDLE;
  logic        dock_en     = 1'b0;
  transition_t expected_transitions[$];
  int          mismatch_count = 0;

  assign errors = mismatch_count;

  // Apply one event to the mirrored state and build the record it should produce
  function automatic transition_t advance_mission(input logic [3:0] ev);
    transition_t rec;
    logic [3:0]  nxt;
    logic        ok;
    logic [4:0]  why;
    logic        pause_ev;
    pause_ev = ev inside {EV_PAUSE, EV_TAKEOVER, EV_LINK, EV_SAFETY, EV_AUTHORITY};
    rec.from_mode = sup_mode;
    nxt = sup_mode;
    ok  = 1'b1;
    why = RSN_UNKNOWN_MODE;
    case (sup_mode)
      MODE_IDLE: begin
        if (ev == EV_CONFIGURED) begin
          nxt = MODE_READY;
          why = RSN_CONFIGURED;
        end else if (ev == EV_STOP) begin
          why = RSN_ALREADY_STOPPED;
        end else begin
          ok  = 1'b0;
          why = RSN_INVALID_IDLE;
        end
      end
      MODE_READY: begin
        if (ev == EV_START) begin
          nxt = MODE_RUNNING;
          why = RSN_STARTED;
        end else if (ev == EV_STOP) begin
          nxt = MODE_IDLE;
          why = RSN_READY_CLEARED;
        end else begin
          ok  = 1'b0;
          why = RSN_INVALID_READY;
        end
      end
      MODE_RUNNING, MODE_RETURNING: begin
        // Halting events go through pausing and remember the active mode
        if (pause_ev || ev == EV_STOP || ev == EV_FATAL) begin
          resume_goal = sup_mode;
          nxt = MODE_PAUSING;
          if (pause_ev) begin
            halt_goal = MODE_PAUSED;
            why = RSN_HALT_PAUSE;
          end else if (ev == EV_STOP) begin
            halt_goal = MODE_IDLE;
            why = RSN_HALT_CLEAR;
          end else begin
            halt_goal = MODE_FAILED;
            why = RSN_HALT_FAIL;
          end
        end else if (sup_mode == MODE_RUNNING && ev == EV_INSPECTION) begin
          nxt = dock_en ? MODE_RETURNING : MODE_COMPLETED;
          why = dock_en ? RSN_DOCK_STARTED : RSN_INSPECTION_DONE;
        end else if (sup_mode == MODE_RETURNING && ev == EV_RETURN) begin
          nxt = MODE_COMPLETED;
          why = RSN_DOCK_DONE;
        end else begin
          ok  = 1'b0;
          why = RSN_INVALID_ACTIVE;
        end
      end
      MODE_PAUSING: begin
        if (ev == EV_QUIESCED) begin
          nxt = halt_goal;
          why = RSN_QUIESCENT;
        end else if (ev == EV_STOP) begin
          halt_goal = MODE_IDLE;
          why = RSN_STOP_RECORDED;
        end else if (ev == EV_FATAL) begin
          // A recorded stop outranks a later failure
          if (halt_goal != MODE_IDLE) halt_goal = MODE_FAILED;
          why = RSN_FAIL_RECORDED;
        end else if (pause_ev) begin
          why = RSN_PAUSE_IN_PROGRESS;
        end else begin
          ok  = 1'b0;
          why = RSN_INVALID_PAUSING;
        end
      end
      MODE_PAUSED: begin
        if (ev == EV_RESUME) begin
          nxt = MODE_RECOVERING;
          why = RSN_RECOVERY_STARTED;
        end else if (ev == EV_STOP) begin
          nxt = MODE_IDLE;
          why = RSN_PAUSED_CLEARED;
        end else if (pause_ev) begin
          why = RSN_ALREADY_PAUSED;
        end else begin
          ok  = 1'b0;
          why = RSN_INVALID_PAUSED;
        end
      end
      MODE_RECOVERING: begin
        if (ev == EV_RECOVERY) begin
          nxt = resume_goal;
          why = RSN_PHASE_RESTARTED;
        end else if (ev == EV_SAFETY || ev == EV_LINK) begin
          nxt = MODE_PAUSED;
          why = RSN_RECOVERY_CANCEL;
        end else if (ev == EV_STOP) begin
          nxt = MODE_IDLE;
          why = RSN_RECOVER_CLEARED;
        end else begin
          ok  = 1'b0;
          why = RSN_INVALID_RECOVER;
        end
      end
      MODE_COMPLETED, MODE_FAILED: begin
        if (ev == EV_RESET || ev == EV_STOP) begin
          nxt = MODE_IDLE;
          why = RSN_TERMINAL_CLEARED;
        end else begin
          ok  = 1'b0;
          why = RSN_TERMINAL_RESET;
        end
      end
      default: begin
        ok  = 1'b0;
        why = RSN_UNKNOWN_MODE;
      end
    endcase
    sup_mode = nxt;
    rec.to_mode        = nxt;
    rec.accepted       = ok;
    rec.reason_code    = why;
    rec.motion_allowed = (nxt == MODE_RUNNING) || (nxt == MODE_RETURNING);
    rec.halt_goal      = halt_goal;
    rec.resume_goal    = resume_goal;
    return rec;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track config writes, score results and queue predictions
  always @(posedge clk) begin
    transition_t want;
    transition_t got;
    if (rst) begin
      sup_mode    = MODE_IDLE;
      halt_goal   = MODE_IDLE;
      resume_goal = MODE_IDLE;
      dock_en     = 1'b0;
      expected_transitions.delete();
    end else begin
      if (cfg_wr_en && sup_mode == MODE_IDLE) dock_en = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        got.from_mode      = m_tdata[3:0];
        got.to_mode        = m_tdata[7:4];
        got.accepted       = m_tdata[8];
        got.reason_code    = m_tdata[13:9];
        got.motion_allowed = m_tdata[14];
        got.halt_goal      = m_tdata[18:15];
        got.resume_goal    = m_tdata[22:19];
        if (expected_transitions.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %h",
                   $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_transitions.pop_front();
          check_field("from_mode", want.from_mode, got.from_mode);
          check_field("to_mode", want.to_mode, got.to_mode);
          check_field("accepted", want.accepted, got.accepted);
          check_field("reason_code", want.reason_code, got.reason_code);
          check_field("motion_allowed", want.motion_allowed, got.motion_allowed);
          check_field("halt_goal", want.halt_goal, got.halt_goal);
          check_field("resume_goal", want.resume_goal, got.resume_goal);
        end
      end
      if (s_tvalid && s_tready) expected_transitions.push_back(advance_mission(s_tdata[3:0]));
    end
    pending <= expected_transitions.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for mission_supervisor_fsm: clock, reset, event stimulus and verdict.
// Instantiates the block and msf_transition_checker; depends on msf_pkg.
`timescale 1ns / 1ps

module tb;
  import msf_pkg::*;

  localparam logic [3:0] EV_UNUSED      = 4'd15;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         PHASE_EVENTS   = 634;

  localparam logic [3:0] PAUSE_EVS [5] = '{EV_PAUSE, EV_TAKEOVER, EV_LINK, EV_SAFETY,
                                           EV_AUTHORITY};
  // Plain path, terminal modes and the unused code
  localparam logic [3:0] RUN_PLAIN [8] = '{EV_UNUSED, EV_STOP, EV_CONFIGURED, EV_SAFETY,
                                           EV_START, EV_INSPECTION, EV_RESET,
                                           EV_CONFIGURED};
  // Completion with dock still off, then stop outranking failure
  localparam logic [3:0] RUN_HALTS [10] = '{EV_START, EV_INSPECTION, EV_RESET,
                                            EV_CONFIGURED, EV_START, EV_FATAL, EV_STOP,
                                            EV_FATAL, EV_PAUSE, EV_QUIESCED};
  // Dock approach with a pause, a cancelled recovery and a restart
  localparam logic [3:0] RUN_DOCK [11] = '{EV_CONFIGURED, EV_START, EV_INSPECTION, EV_LINK,
                                           EV_QUIESCED, EV_RESUME, EV_SAFETY, EV_RESUME,
                                           EV_RECOVERY, EV_RETURN, EV_STOP};

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata     = 8'h00;
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;
  int                  mismatches;
  int                  outstanding;
  int                  send_idle_pct = 37;
  int                  recv_idle_pct = 70;
  int                  quiet_cycles  = 0;
  int                  sent_events   = 0;

  mission_supervisor_fsm u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  msf_transition_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .errors     (mismatches),
    .pending    (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Throttle the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one event, idling at random first, and hold it until accepted
  task automatic send_event(input logic [3:0] ev);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, ev};
    do @(posedge clk); while (!s_tready);
    sent_events++;
  endtask

  // Hold off the event side until every result has arrived
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dock(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [3:0] pick_pause();
    return PAUSE_EVS[$urandom_range(4)];
  endfunction

  // One mission from idle with random content, closed by a stop chain back to idle
  task automatic send_mission();
    int segs;
    segs = $urandom_range(1, 3);
    send_event(EV_CONFIGURED);
    send_event(EV_START);
    repeat (segs) begin
      case ($urandom_range(4))
        0, 1: begin
          // Pause, maybe change the halt goal, quiesce, recover
          send_event(pick_pause());
          repeat ($urandom_range(2)) begin
            case ($urandom_range(2))
              0: send_event(EV_STOP);
              1: send_event(EV_FATAL);
              default: send_event(pick_pause());
            endcase
          end
          send_event(EV_QUIESCED);
          send_event(EV_RESUME);
          if ($urandom_range(3) == 0) begin
            send_event($urandom_range(1) ? EV_SAFETY : EV_LINK);
            send_event(EV_RESUME);
          end
          send_event(EV_RECOVERY);
        end
        2: begin
          send_event(EV_FATAL);
          send_event(EV_QUIESCED);
          send_event($urandom_range(1) ? EV_RESET : EV_STOP);
          send_event(EV_CONFIGURED);
          send_event(EV_START);
        end
        default: begin
          repeat ($urandom_range(1, 3)) send_event(4'($urandom_range(15)));
        end
      endcase
    end
    if ($urandom_range(1)) begin
      send_event(EV_INSPECTION);
      if ($urandom_range(3) != 0) send_event(EV_RETURN);
      send_event($urandom_range(1) ? EV_RESET : EV_STOP);
    end
    send_event(EV_STOP);
    send_event(EV_STOP);
    send_event(EV_QUIESCED);
    send_event(EV_STOP);
  endtask

  // Stimulus and verdict
  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (RUN_PLAIN[i]) send_event(RUN_PLAIN[i]);
    // Mode is ready here, so this write must be dropped
    settle();
    write_dock(1'b1);
    foreach (RUN_HALTS[i]) send_event(RUN_HALTS[i]);
    settle();
    write_dock(1'b1);
    foreach (RUN_DOCK[i]) send_event(RUN_DOCK[i]);

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 70;
          write_dock(1'b0);
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 37;
          write_dock(1'b1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_dock(1'($urandom_range(1)));
        end
      endcase
      target = sent_events + PHASE_EVENTS;
      while (sent_events < target) send_mission();
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/msf_pkg.sv
design/msf_decode.sv
design/mission_supervisor_fsm.sv
design/msf_checker.sv
dv/msf_transition_checker.sv
dv/tb.sv
